[hw/rtl/qsched_pkg.sv]
// Shared types and constants for the round-robin quantum scheduler.
package qsched_pkg;

    localparam int PID_W       = 4;
    localparam int BURST_W     = 16;
    localparam int QUANTUM_W   = 8;
    localparam int PORT_TIME_W = 16;
    localparam int STATUS_W    = 2;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd2;

    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ACTIVE     = 2'd1,
        STATUS_ZERO_BURST = 2'd2
    } status_t;

    // ready-queue control from the sequencer
    typedef struct packed {
        logic push;
        logic rd;
        logic pop;
    } qctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } divstat_t;

endpackage

[hw/rtl/qsched_queue.sv]
// Circular FIFO of process ids (ready queue) with registered head read.
module qsched_queue #(
    parameter int MAX_PROCS = 16,
    localparam int ID_W = $clog2(MAX_PROCS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  qsched_pkg::qctl_t ctl,
    input  logic [ID_W-1:0]   push_id,
    output logic [ID_W-1:0]   head_id,
    output qsched_pkg::qstat_t stat
);
    import qsched_pkg::*;

    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam logic [ID_W-1:0]  LAST_IDX = ID_W'(MAX_PROCS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCS);

    logic [ID_W-1:0]  mem [MAX_PROCS];
    logic [ID_W-1:0]  head_reg, head_next;
    logic [ID_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ID_W-1:0]  rdata_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.push) begin
            tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
        end
        if (ctl.pop) begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end
        if (ctl.push && !ctl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (ctl.pop && !ctl.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[tail_reg] <= push_id;
        end
        if (ctl.rd) begin
            rdata_reg <= mem[head_reg];
        end
    end

    assign head_id    = rdata_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == FULL_CNT);

endmodule

[hw/rtl/qsched_div.sv]
// Restoring divider, one quotient bit per cycle, for weighted turnaround.
module qsched_div #(
    parameter int N_W = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [N_W-1:0]                dividend,
    input  logic [qsched_pkg::BURST_W-1:0] divisor,
    output logic [N_W-1:0]                quotient,
    output qsched_pkg::divstat_t          stat
);
    import qsched_pkg::*;

    localparam int CNT_W = $clog2(N_W + 1);

    logic [BURST_W:0]   rem_reg, rem_next;
    logic [N_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [BURST_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg[BURST_W-1:0], quo_reg[N_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? (trial - {1'b0, divisor}) : trial;
            quo_next = {quo_reg[N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[hw/rtl/round_robin_quantum_scheduler_core.sv]
// Round-robin time-slice scheduler: sequencer, process table and result register.
//
// Input channel (s_*): one word is either an arrival (s_mode 0: s_proc_id,
// s_burst_length) or one tick of execution (s_mode 1). Each accepted word
// produces exactly one result word on the m_* channel.
// cfg_data sets the quantum (ticks per time slice, 0 acts as 1); cfg_ready
// is always high and cfg_data is taken whenever cfg_valid is high, even mid-word.
// An arrival passes the check step and then the output step. A tick passes
// requeue and select, a pop when a process is taken from the queue, the run
// step, an update when a process holds the CPU, and the output step; when the
// running process completes, the bit-serial divider that forms the weighted
// turnaround runs between update and output. One word is processed at a time:
// s_ready is high only while the sequencer is idle, so the next word is
// accepted in the cycle after the result is loaded.
// The result sits in an output register; the next word is accepted while it
// waits, and a stalled receiver only holds the sequencer at its final step.
// Reset (aresetn low, synchronous) clears the clock, the queue, all active
// flags and sets the quantum to 2. Table contents need no clearing.
module round_robin_quantum_scheduler_core #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [qsched_pkg::PID_W-1:0]      s_proc_id,
    input  logic [qsched_pkg::BURST_W-1:0]    s_burst_length,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [qsched_pkg::STATUS_W-1:0]   m_status,
    output logic [qsched_pkg::PORT_TIME_W-1:0] m_current_time,
    output logic                              m_running_valid,
    output logic [qsched_pkg::PID_W-1:0]      m_running_id,
    output logic                              m_finished,
    output logic [qsched_pkg::PID_W-1:0]      m_finished_id,
    output logic [qsched_pkg::PORT_TIME_W-1:0] m_turnaround,
    output logic [qsched_pkg::PORT_TIME_W-1:0] m_weighted_turnaround,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qsched_pkg::QUANTUM_W-1:0]  cfg_data
);
    import qsched_pkg::*;

    localparam int ID_W = $clog2(MAX_PROCS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_REQUEUE,
        ST_SELECT,
        ST_POP,
        ST_RUN,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [PID_W-1:0]     pid_reg, pid_next;
    logic [BURST_W-1:0]   burst_reg, burst_next;
    logic [MAX_PROCS-1:0] active_reg, active_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [ID_W-1:0]      holder_reg, holder_next;
    logic                 present_reg, present_next;
    logic [QUANTUM_W-1:0] slice_reg, slice_next;
    logic                 rq_pending_reg, rq_pending_next;
    logic [ID_W-1:0]      rq_holder_reg, rq_holder_next;
    logic [QUANTUM_W-1:0] quantum_reg;

    status_t              res_status_reg, res_status_next;
    logic                 res_run_reg, res_run_next;
    logic                 res_fin_reg, res_fin_next;
    logic [TIME_BITS-1:0] res_ta_reg, res_ta_next;
    logic [TIME_BITS-1:0] res_wt_reg, res_wt_next;

    logic                   out_valid_reg;
    status_t                out_status_reg;
    logic [PORT_TIME_W-1:0] out_time_reg;
    logic                   out_run_reg;
    logic [PID_W-1:0]       out_run_id_reg;
    logic                   out_fin_reg;
    logic [PID_W-1:0]       out_fin_id_reg;
    logic [PORT_TIME_W-1:0] out_ta_reg;
    logic [PORT_TIME_W-1:0] out_wt_reg;
    logic                   emit;

    // process table
    logic [BURST_W-1:0]   rem_mem [MAX_PROCS];
    logic [TIME_BITS-1:0] arr_mem [MAX_PROCS];
    logic [BURST_W-1:0]   bur_mem [MAX_PROCS];
    logic [BURST_W-1:0]   rem_rd_reg;
    logic [TIME_BITS-1:0] arr_rd_reg;
    logic [BURST_W-1:0]   bur_rd_reg;
    logic                 rem_we;
    logic [ID_W-1:0]      rem_waddr;
    logic [BURST_W-1:0]   rem_wdata;
    logic                 arrive_we;

    qctl_t                qctl;
    qstat_t               qstat;
    logic [ID_W-1:0]      q_push_id;
    logic [ID_W-1:0]      q_head_id;

    logic                 div_start;
    logic [TIME_BITS-1:0] div_quo;
    divstat_t             dstat;

    logic [ID_W-1:0]      pid_idx;
    logic                 pid_in_range;
    logic [QUANTUM_W-1:0] q_eff;
    logic [BURST_W-1:0]   rem_dec;
    logic [QUANTUM_W-1:0] slice_inc;
    logic [TIME_BITS-1:0] ta_calc;

    assign pid_idx      = ID_W'(pid_reg);
    assign pid_in_range = ({28'd0, pid_reg} < 32'(MAX_PROCS));
    assign q_eff        = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    assign rem_dec      = (rem_rd_reg != '0) ? rem_rd_reg - 1'b1 : '0;
    assign slice_inc    = slice_reg + 1'b1;
    assign ta_calc      = time_reg - arr_rd_reg;
    assign emit         = (state_reg == ST_EMIT) && (!out_valid_reg || m_ready);

    qsched_queue #(
        .MAX_PROCS(MAX_PROCS)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (qctl),
        .push_id (q_push_id),
        .head_id (q_head_id),
        .stat    (qstat)
    );

    qsched_div #(
        .N_W(TIME_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ta_calc),
        .divisor  (bur_rd_reg),
        .quotient (div_quo),
        .stat     (dstat)
    );

    always_comb begin
        state_next      = state_reg;
        pid_next        = pid_reg;
        burst_next      = burst_reg;
        active_next     = active_reg;
        time_next       = time_reg;
        holder_next     = holder_reg;
        present_next    = present_reg;
        slice_next      = slice_reg;
        rq_pending_next = rq_pending_reg;
        rq_holder_next  = rq_holder_reg;
        res_status_next = res_status_reg;
        res_run_next    = res_run_reg;
        res_fin_next    = res_fin_reg;
        res_ta_next     = res_ta_reg;
        res_wt_next     = res_wt_reg;
        qctl            = '0;
        q_push_id       = pid_idx;
        div_start       = 1'b0;
        rem_we          = 1'b0;
        rem_waddr       = holder_reg;
        rem_wdata       = rem_dec;
        arrive_we       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pid_next        = s_proc_id;
                    burst_next      = s_burst_length;
                    res_status_next = STATUS_OK;
                    res_run_next    = 1'b0;
                    res_fin_next    = 1'b0;
                    res_ta_next     = '0;
                    res_wt_next     = '0;
                    state_next      = (s_mode == MODE_TICK) ? ST_REQUEUE : ST_ARRIVE;
                end
            end
            ST_ARRIVE: begin
                if (burst_reg == '0) begin
                    res_status_next = STATUS_ZERO_BURST;
                end else if (!pid_in_range || active_reg[pid_idx] || qstat.full) begin
                    res_status_next = STATUS_ACTIVE;
                end else begin
                    qctl.push            = 1'b1;
                    active_next[pid_idx] = 1'b1;
                    arrive_we            = 1'b1;
                    rem_we               = 1'b1;
                    rem_waddr            = pid_idx;
                    rem_wdata            = burst_reg;
                end
                state_next = ST_EMIT;
            end
            ST_REQUEUE: begin
                // preempted process goes in behind arrivals made since its slice ended
                if (rq_pending_reg) begin
                    qctl.push       = 1'b1;
                    q_push_id       = rq_holder_reg;
                    rq_pending_next = 1'b0;
                end
                state_next = ST_SELECT;
            end
            ST_SELECT: begin
                if (!present_reg && !qstat.empty) begin
                    qctl.rd    = 1'b1;
                    state_next = ST_POP;
                end else begin
                    state_next = ST_RUN;
                end
            end
            ST_POP: begin
                qctl.pop     = 1'b1;
                holder_next  = q_head_id;
                present_next = 1'b1;
                slice_next   = '0;
                state_next   = ST_RUN;
            end
            ST_RUN: begin
                // table reads for holder_reg land at the end of this cycle
                time_next  = time_reg + 1'b1;
                state_next = present_reg ? ST_UPDATE : ST_EMIT;
            end
            ST_UPDATE: begin
                res_run_next = 1'b1;
                rem_we       = 1'b1;
                if (rem_dec == '0) begin
                    res_fin_next        = 1'b1;
                    res_ta_next         = ta_calc;
                    active_next[holder_reg] = 1'b0;
                    present_next        = 1'b0;
                    slice_next          = '0;
                    div_start           = 1'b1;
                    state_next          = ST_DIVIDE;
                end else if (slice_inc >= q_eff) begin
                    rq_pending_next = 1'b1;
                    rq_holder_next  = holder_reg;
                    present_next    = 1'b0;
                    slice_next      = '0;
                    state_next      = ST_EMIT;
                end else begin
                    slice_next = slice_inc;
                    state_next = ST_EMIT;
                end
            end
            ST_DIVIDE: begin
                if (dstat.done) begin
                    res_wt_next = (bur_rd_reg == '0) ? '0 : div_quo;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            active_reg     <= '0;
            time_reg       <= '0;
            holder_reg     <= '0;
            present_reg    <= 1'b0;
            slice_reg      <= '0;
            rq_pending_reg <= 1'b0;
            rq_holder_reg  <= '0;
            quantum_reg    <= QUANTUM_RESET;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            time_reg       <= time_next;
            holder_reg     <= holder_next;
            present_reg    <= present_next;
            slice_reg      <= slice_next;
            rq_pending_reg <= rq_pending_next;
            rq_holder_reg  <= rq_holder_next;
            if (cfg_valid) begin
                quantum_reg <= cfg_data;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        pid_reg        <= pid_next;
        burst_reg      <= burst_next;
        res_status_reg <= res_status_next;
        res_run_reg    <= res_run_next;
        res_fin_reg    <= res_fin_next;
        res_ta_reg     <= res_ta_next;
        res_wt_reg     <= res_wt_next;
        if (emit) begin
            out_status_reg <= res_status_reg;
            out_time_reg   <= PORT_TIME_W'(time_reg);
            out_run_reg    <= res_run_reg;
            out_run_id_reg <= res_run_reg ? PID_W'(holder_reg) : '0;
            out_fin_reg    <= res_fin_reg;
            out_fin_id_reg <= res_fin_reg ? PID_W'(holder_reg) : '0;
            out_ta_reg     <= PORT_TIME_W'(res_ta_reg);
            out_wt_reg     <= PORT_TIME_W'(res_wt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rem_we) begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (arrive_we) begin
            arr_mem[pid_idx] <= time_reg;
            bur_mem[pid_idx] <= burst_reg;
        end
        rem_rd_reg <= rem_mem[holder_reg];
        arr_rd_reg <= arr_mem[holder_reg];
        bur_rd_reg <= bur_mem[holder_reg];
    end

    assign s_ready               = (state_reg == ST_IDLE);
    assign cfg_ready             = 1'b1;
    assign m_valid               = out_valid_reg;
    assign m_status              = out_status_reg;
    assign m_current_time        = out_time_reg;
    assign m_running_valid       = out_run_reg;
    assign m_running_id          = out_run_id_reg;
    assign m_finished            = out_fin_reg;
    assign m_finished_id         = out_fin_id_reg;
    assign m_turnaround          = out_ta_reg;
    assign m_weighted_turnaround = out_wt_reg;

`ifndef ASSERT_OFF
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        qctl.push |-> !qstat.full)
        else $error("push into full ready queue");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !dstat.busy)
        else $error("divider restarted while busy");

    a_fin_has_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> m_running_valid)
        else $error("completion reported without a running process");

    a_reject_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_OK)) |-> (!m_running_valid && !m_finished))
        else $error("rejected arrival carries tick fields");

    a_no_push_and_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        qctl.pop |-> (!qctl.push && !qstat.empty))
        else $error("pop from empty queue or together with push");
`endif

endmodule
